// ===== sv/sce_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sce_pkg: shared types and codes for the stack calculator engine
// Request and response word layouts, command and status codes, and the
// control word of the iterative multiply/divide unit.
// ----------------------------------------------------------------------------
package sce_pkg;

   localparam logic [3:0] CMD_PUSH  = 4'd0;
   localparam logic [3:0] CMD_POP   = 4'd1;
   localparam logic [3:0] CMD_CLEAR = 4'd2;
   localparam logic [3:0] CMD_ADD   = 4'd3;
   localparam logic [3:0] CMD_SUB   = 4'd4;
   localparam logic [3:0] CMD_MUL   = 4'd5;
   localparam logic [3:0] CMD_DIV   = 4'd6;
   localparam logic [3:0] CMD_MOD   = 4'd7;
   localparam logic [3:0] CMD_NEQ   = 4'd8;
   localparam logic [3:0] CMD_EQ    = 4'd9;
   localparam logic [3:0] CMD_LT    = 4'd10;
   localparam logic [3:0] CMD_LE    = 4'd11;
   localparam logic [3:0] CMD_GT    = 4'd12;
   localparam logic [3:0] CMD_GE    = 4'd13;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_UNDERFLOW = 2'd1;
   localparam logic [1:0] ST_OVERFLOW  = 2'd2;
   localparam logic [1:0] ST_DIV_ZERO  = 2'd3;

   typedef struct packed {
      logic [3:0]          command;
      logic signed [31:0]  push_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0]  top_value;
      logic                not_empty;
      logic [4:0]          stack_depth;
      logic                compare_flag;
      logic [1:0]          status;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic is_div;
   } unit_ctl_type;

endpackage

// ===== sv/sce_iter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sce_iter_unit: iterative unsigned multiply / restoring divide
// One shared 33-bit adder does a shift-add multiply step or a restoring
// divide step per cycle. Multiply: 32 steps, product in {hi, lo[31:0]}.
// Divide: 32+FRAC_BITS steps, quotient in lo, remainder in hi.
// ----------------------------------------------------------------------------
module sce_iter_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sce_pkg::unit_ctl_type         ctl,
   input  logic [32+FRAC_BITS-1:0]       op_x,
   input  logic [31:0]                   op_y,
   output logic                          done,
   output logic [31:0]                   result_hi,
   output logic [32+FRAC_BITS-1:0]       result_lo
);

   localparam int DVD_W = 32 + FRAC_BITS;
   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [31:0]       hi_ff, hi_in;
   logic [DVD_W-1:0]  lo_ff, lo_in;
   logic [31:0]       y_ff;
   logic              is_div_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              running_ff;
   logic              done_ff;

   logic [32:0]       add_a, add_b;
   logic              add_sub;
   logic [33:0]       add_sum;
   logic [32:0]       shifted;

   assign shifted = {hi_ff, lo_ff[DVD_W-1]};

   always_comb begin
      if (is_div_ff) begin
         add_a   = shifted;
         add_b   = {1'b0, y_ff};
         add_sub = 1'b1;
      end else begin
         add_a   = {1'b0, hi_ff};
         add_b   = {1'b0, lo_ff[0] ? y_ff : 32'd0};
         add_sub = 1'b0;
      end
      add_sum = {1'b0, add_a} + {1'b0, add_sub ? ~add_b : add_b} + {33'd0, add_sub};
   end

   always_comb begin
      lo_in = lo_ff;
      if (is_div_ff) begin
         // carry out set: no borrow, quotient bit is one
         hi_in = add_sum[33] ? add_sum[31:0] : shifted[31:0];
         lo_in = {lo_ff[DVD_W-2:0], add_sum[33]};
      end else begin
         hi_in       = add_sum[32:1];
         lo_in[31:0] = {add_sum[0], lo_ff[31:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            running_ff <= 1'b1;
         end else if (running_ff && (count_ff == '0)) begin
            running_ff <= 1'b0;
            done_ff    <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         hi_ff     <= '0;
         lo_ff     <= op_x;
         y_ff      <= op_y;
         is_div_ff <= ctl.is_div;
         count_ff  <= ctl.is_div ? CNT_W'(DVD_W - 1) : CNT_W'(31);
      end else if (running_ff) begin
         hi_ff    <= hi_in;
         lo_ff    <= lo_in;
         count_ff <= count_ff - CNT_W'(1);
      end
   end

   assign done      = done_ff;
   assign result_hi = hi_ff;
   assign result_lo = lo_ff;

   a_done_after_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(running_ff) && !running_ff)
      else $error("unit done without a finished run");

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      running_ff |-> !ctl.start)
      else $error("unit started while running");

   a_div_rem_bound: assert property (@(posedge clock) disable iff (reset)
      done_ff && is_div_ff |-> hi_ff < y_ff)
      else $error("remainder not below divisor");

endmodule

// ===== sv/stack_calculator_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_calculator_engine: RPN operand stack of signed fixed-point values
// From accept: S_DISPATCH, then S_TOP_RD for push/pop/clear/unused and
// underflow; else S_READ_B, S_READ_A, S_EXEC, where compares and a zero
// divisor go to S_TOP_RD, add/sub via S_WRITE, mul (32 shift-add steps) and
// div/mod (one restoring step per dividend bit) via the shared iterative
// unit, S_FIX and S_WRITE. Reads use the registered stack RAM port. busy is
// high from accept until the strobe cycle; the next word may start in the
// strobe cycle. Synchronous reset empties the stack; RAM is not cleared.
// ----------------------------------------------------------------------------
module stack_calculator_engine #(
   parameter int STACK_DEPTH = 16,
   parameter int FRAC_BITS   = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  sce_pkg::req_type  req_word,
   output logic              rsp_strobe,
   output sce_pkg::rsp_type  rsp_word
);

   localparam int PTR_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int DVD_W  = 32 + FRAC_BITS;
   localparam logic [63:0] ROUND_UP = (64'd1 << FRAC_BITS) - 64'd1;

   typedef enum logic [8:0] {
      S_IDLE      = 9'b000000001,
      S_DISPATCH  = 9'b000000010,
      S_READ_B    = 9'b000000100,
      S_READ_A    = 9'b000001000,
      S_EXEC      = 9'b000010000,
      S_UNIT_WAIT = 9'b000100000,
      S_FIX       = 9'b001000000,
      S_WRITE     = 9'b010000000,
      S_TOP_RD    = 9'b100000000
   } state_type;

   // S_TOP_RD issues the top read; the response is built on the following
   // cycle, marked by rsp_pend_ff.
   state_type          state_ff, state_in;
   logic               rsp_pend_ff, rsp_pend_in;
   logic [3:0]         cmd_ff, cmd_in;
   logic [31:0]        pv_ff, pv_in;
   logic [PTR_W-1:0]   sp_ff, sp_in;
   logic [1:0]         status_ff, status_in;
   logic               cmp_ff, cmp_in;
   logic [31:0]        a_ff, a_in;
   logic [31:0]        b_ff, b_in;
   logic [31:0]        res_ff, res_in;
   sce_pkg::rsp_type   rsp_word_ff, rsp_word_in;
   logic               rsp_strobe_ff, rsp_strobe_in;

   logic [31:0]        mem [STACK_DEPTH];
   logic [31:0]        rd_data_ff;
   logic [ADDR_W-1:0]  rd_addr;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [31:0]        mem_wdata;

   sce_pkg::unit_ctl_type unit_ctl;
   logic [DVD_W-1:0]   unit_x;
   logic [31:0]        unit_y;
   logic               unit_done;
   logic [31:0]        unit_hi;
   logic [DVD_W-1:0]   unit_lo;

   logic [PTR_W-1:0]   sp_m1, sp_m2;
   logic [PTR_W+4:0]   sp_ext;
   logic [31:0]        mag_a, mag_b, mag_b_int;
   logic [32:0]        sum33, diff33;
   logic               lt, eq, prod_neg;
   logic [63:0]        prod, mul_mag;
   logic [31:0]        rem_signed;

   function automatic logic [31:0] sat33(input logic [32:0] v);
      if (v[32] != v[31]) begin
         return v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      return v[31:0];
   endfunction

   function automatic logic [31:0] sat_mag(input logic neg, input logic [63:0] mag);
      if (!neg) begin
         return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
      end
      return (mag > 64'h8000_0000) ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
   endfunction

   assign sp_m1  = sp_ff - PTR_W'(1);
   assign sp_m2  = sp_ff - PTR_W'(2);
   assign sp_ext = {5'd0, sp_ff};

   assign mag_a     = rd_data_ff[31] ? (~rd_data_ff + 32'd1) : rd_data_ff;
   assign mag_b     = b_ff[31] ? (~b_ff + 32'd1) : b_ff;
   assign mag_b_int = mag_b >> FRAC_BITS;

   assign sum33  = {rd_data_ff[31], rd_data_ff} + {b_ff[31], b_ff};
   assign diff33 = {rd_data_ff[31], rd_data_ff} - {b_ff[31], b_ff};
   assign lt     = diff33[32];
   assign eq     = (rd_data_ff == b_ff);

   assign prod_neg   = a_ff[31] ^ b_ff[31];
   assign prod       = {unit_hi, unit_lo[31:0]};
   assign mul_mag    = prod_neg ? ((prod + ROUND_UP) >> FRAC_BITS) : (prod >> FRAC_BITS);
   assign rem_signed = a_ff[31] ? (~unit_hi + 32'd1) : unit_hi;

   always_comb begin
      state_in      = state_ff;
      rsp_pend_in   = 1'b0;
      cmd_in        = cmd_ff;
      pv_in         = pv_ff;
      sp_in         = sp_ff;
      status_in     = status_ff;
      cmp_in        = cmp_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      res_in        = res_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_strobe_in = 1'b0;
      rd_addr       = sp_m1[ADDR_W-1:0];
      mem_we        = 1'b0;
      mem_waddr     = sp_ff[ADDR_W-1:0];
      mem_wdata     = pv_ff;
      unit_ctl      = '0;
      unit_x        = DVD_W'(mag_a);
      unit_y        = mag_b;

      if (rsp_pend_ff) begin
         rsp_word_in.top_value    = (sp_ff == '0) ? 32'sd0 : rd_data_ff;
         rsp_word_in.not_empty    = (sp_ff != '0);
         rsp_word_in.stack_depth  = sp_ext[4:0];
         rsp_word_in.compare_flag = cmp_ff;
         rsp_word_in.status       = status_ff;
         rsp_strobe_in            = 1'b1;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start && !rsp_pend_ff) begin
               cmd_in    = req_word.command;
               pv_in     = req_word.push_value;
               status_in = sce_pkg::ST_OK;
               cmp_in    = 1'b0;
               state_in  = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_TOP_RD;
            unique case (cmd_ff) inside
               sce_pkg::CMD_PUSH: begin
                  if (sp_ff >= PTR_W'(STACK_DEPTH)) begin
                     status_in = sce_pkg::ST_OVERFLOW;
                  end else begin
                     mem_we = 1'b1;
                     sp_in  = sp_ff + PTR_W'(1);
                  end
               end
               sce_pkg::CMD_POP: begin
                  if (sp_ff == '0) begin
                     status_in = sce_pkg::ST_UNDERFLOW;
                  end else begin
                     sp_in = sp_m1;
                  end
               end
               sce_pkg::CMD_CLEAR: begin
                  sp_in = '0;
               end
               sce_pkg::CMD_ADD, sce_pkg::CMD_SUB, sce_pkg::CMD_MUL, sce_pkg::CMD_DIV,
               sce_pkg::CMD_MOD, sce_pkg::CMD_NEQ, sce_pkg::CMD_EQ, sce_pkg::CMD_LT,
               sce_pkg::CMD_LE, sce_pkg::CMD_GT, sce_pkg::CMD_GE: begin
                  if (sp_ff < PTR_W'(2)) begin
                     status_in = sce_pkg::ST_UNDERFLOW;
                  end else begin
                     state_in = S_READ_B;
                  end
               end
               default: begin
               end
            endcase
         end
         S_READ_B: begin
            state_in = S_READ_A;
         end
         S_READ_A: begin
            b_in     = rd_data_ff;
            rd_addr  = sp_m2[ADDR_W-1:0];
            state_in = S_EXEC;
         end
         S_EXEC: begin
            a_in = rd_data_ff;
            unique case (cmd_ff) inside
               sce_pkg::CMD_ADD: begin
                  res_in   = sat33(sum33);
                  state_in = S_WRITE;
               end
               sce_pkg::CMD_SUB: begin
                  res_in   = sat33(diff33);
                  state_in = S_WRITE;
               end
               sce_pkg::CMD_MUL: begin
                  unit_ctl.start = 1'b1;
                  state_in       = S_UNIT_WAIT;
               end
               sce_pkg::CMD_DIV: begin
                  if (b_ff == '0) begin
                     status_in = sce_pkg::ST_DIV_ZERO;
                     state_in  = S_TOP_RD;
                  end else begin
                     unit_ctl.start  = 1'b1;
                     unit_ctl.is_div = 1'b1;
                     unit_x          = DVD_W'(mag_a) << FRAC_BITS;
                     state_in        = S_UNIT_WAIT;
                  end
               end
               sce_pkg::CMD_MOD: begin
                  unit_x = DVD_W'(mag_a >> FRAC_BITS);
                  unit_y = mag_b_int;
                  if (mag_b_int == '0) begin
                     status_in = sce_pkg::ST_DIV_ZERO;
                     state_in  = S_TOP_RD;
                  end else begin
                     unit_ctl.start  = 1'b1;
                     unit_ctl.is_div = 1'b1;
                     state_in        = S_UNIT_WAIT;
                  end
               end
               default: begin
                  unique case (cmd_ff)
                     sce_pkg::CMD_NEQ: cmp_in = !eq;
                     sce_pkg::CMD_EQ:  cmp_in = eq;
                     sce_pkg::CMD_LT:  cmp_in = lt;
                     sce_pkg::CMD_LE:  cmp_in = lt || eq;
                     sce_pkg::CMD_GT:  cmp_in = !(lt || eq);
                     default:          cmp_in = !lt;
                  endcase
                  sp_in    = sp_m2;
                  state_in = S_TOP_RD;
               end
            endcase
         end
         S_UNIT_WAIT: begin
            if (unit_done) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            unique case (cmd_ff)
               sce_pkg::CMD_MUL: res_in = sat_mag(prod_neg, mul_mag);
               sce_pkg::CMD_DIV: res_in = sat_mag(prod_neg, 64'(unit_lo));
               default:          res_in = rem_signed << FRAC_BITS;
            endcase
            state_in = S_WRITE;
         end
         S_WRITE: begin
            mem_we    = 1'b1;
            mem_waddr = sp_m2[ADDR_W-1:0];
            mem_wdata = res_ff;
            sp_in     = sp_m1;
            state_in  = S_TOP_RD;
         end
         S_TOP_RD: begin
            rsp_pend_in = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_pend_ff   <= 1'b0;
         sp_ff         <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_pend_ff   <= rsp_pend_in;
         sp_ff         <= sp_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      pv_ff       <= pv_in;
      status_ff   <= status_in;
      cmp_ff      <= cmp_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      res_ff      <= res_in;
      rsp_word_ff <= rsp_word_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   sce_iter_unit #(
      .FRAC_BITS (FRAC_BITS)
   ) u_iter (
      .clock     (clock),
      .reset     (reset),
      .ctl       (unit_ctl),
      .op_x      (unit_x),
      .op_y      (unit_y),
      .done      (unit_done),
      .result_hi (unit_hi),
      .result_lo (unit_lo)
   );

   assign busy       = (state_ff != S_IDLE) || rsp_pend_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= PTR_W'(STACK_DEPTH))
      else $error("stack pointer beyond depth");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held longer than one cycle");

   a_flag_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_word.status != sce_pkg::ST_OK) |-> !rsp_word.compare_flag)
      else $error("compare flag set on failed command");

   a_unit_done_wait: assert property (@(posedge clock) disable iff (reset)
      unit_done |-> state_ff == S_UNIT_WAIT)
      else $error("unit finished outside wait state");

endmodule

// ===== verif/tb_stack_calculator_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stack_calculator_engine: self-checking bench for the RPN stack engine
// A shadow operand stack predicts every response word. A queue-fed driver
// issues command words with random gaps. The monitor checks each strobed
// response field by field. Directed corner cases come first, then random
// expression sequences, stack fills and noise.
// ----------------------------------------------------------------------------
module tb_stack_calculator_engine;

   localparam int         STACK_SIZE    = 16;
   localparam int         FRAC          = 16;
   localparam longint     ONE_Q         = longint'(1) << FRAC;
   localparam logic [3:0] CMD_SPARE_LO  = 4'd14;
   localparam logic [3:0] CMD_SPARE_HI  = 4'd15;
   localparam int         RANDOM_WORDS  = 1600;
   localparam int         STALL_LIMIT   = 1000;
   localparam int         TAIL_CYCLES   = 80;

   typedef struct {
      sce_pkg::req_type word;
      bit               drain;
   } pending_type;

   logic             clock    = 1'b0;
   logic             reset    = 1'b1;
   logic             start    = 1'b0;
   sce_pkg::req_type req_word = '0;
   logic             busy;
   logic             rsp_strobe;
   sce_pkg::rsp_type rsp_word;

   pending_type      command_queue[$];
   pending_type      next_item;
   sce_pkg::rsp_type awaited_rsps[$];

   logic signed [31:0] shadow_stack[STACK_SIZE];
   int                 shadow_depth = 0;
   int                 error_count  = 0;
   int                 stall_cycles = 0;
   int                 gap_left     = 0;
   int                 burst_left   = 0;
   logic               word_taken   = 1'b0;

   stack_calculator_engine #(
      .STACK_DEPTH (STACK_SIZE),
      .FRAC_BITS   (FRAC)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic signed [31:0] clamp_word(longint v);
      if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
      if (v < -longint'(32'sh7FFF_FFFF) - 1) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic sce_pkg::rsp_type apply_command(sce_pkg::req_type w);
      sce_pkg::rsp_type   r;
      longint             first_op, second_op, int_first, int_second;
      logic signed [31:0] result_val;
      logic [1:0]         st;
      logic               flag;
      bit                 push_back;
      st         = sce_pkg::ST_OK;
      flag       = 1'b0;
      result_val = '0;
      push_back  = 1'b1;
      case (w.command)
         sce_pkg::CMD_PUSH: begin
            if (shadow_depth >= STACK_SIZE) st = sce_pkg::ST_OVERFLOW;
            else begin
               shadow_stack[shadow_depth] = w.push_value;
               shadow_depth++;
            end
         end
         sce_pkg::CMD_POP: begin
            if (shadow_depth == 0) st = sce_pkg::ST_UNDERFLOW;
            else shadow_depth--;
         end
         sce_pkg::CMD_CLEAR: shadow_depth = 0;
         CMD_SPARE_LO, CMD_SPARE_HI: ;
         default: begin
            if (shadow_depth < 2) st = sce_pkg::ST_UNDERFLOW;
            else begin
               second_op = shadow_stack[shadow_depth - 1];
               first_op  = shadow_stack[shadow_depth - 2];
               case (w.command)
                  sce_pkg::CMD_ADD: result_val = clamp_word(first_op + second_op);
                  sce_pkg::CMD_SUB: result_val = clamp_word(first_op - second_op);
                  sce_pkg::CMD_MUL: result_val = clamp_word((first_op * second_op) >>> FRAC);
                  sce_pkg::CMD_DIV: begin
                     if (second_op == 0) st = sce_pkg::ST_DIV_ZERO;
                     else result_val = clamp_word((first_op * ONE_Q) / second_op);
                  end
                  sce_pkg::CMD_MOD: begin
                     int_first  = first_op / ONE_Q;
                     int_second = second_op / ONE_Q;
                     if (int_second == 0) st = sce_pkg::ST_DIV_ZERO;
                     else result_val = clamp_word((int_first % int_second) * ONE_Q);
                  end
                  default: begin
                     push_back = 1'b0;
                     case (w.command)
                        sce_pkg::CMD_NEQ: flag = (first_op != second_op);
                        sce_pkg::CMD_EQ:  flag = (first_op == second_op);
                        sce_pkg::CMD_LT:  flag = (first_op <  second_op);
                        sce_pkg::CMD_LE:  flag = (first_op <= second_op);
                        sce_pkg::CMD_GT:  flag = (first_op >  second_op);
                        default:          flag = (first_op >= second_op);
                     endcase
                  end
               endcase
               if (st == sce_pkg::ST_OK) begin
                  shadow_depth -= 2;
                  if (push_back) begin
                     shadow_stack[shadow_depth] = result_val;
                     shadow_depth++;
                  end
               end
            end
         end
      endcase
      r.top_value    = (shadow_depth > 0) ? shadow_stack[shadow_depth - 1] : '0;
      r.not_empty    = (shadow_depth > 0);
      r.stack_depth  = 5'(shadow_depth);
      r.compare_flag = flag;
      r.status       = st;
      return r;
   endfunction

   task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
         error_count++;
      end
   endtask

   task automatic check_rsp(sce_pkg::rsp_type got);
      sce_pkg::rsp_type want;
      if (awaited_rsps.size() == 0) begin
         $display("%0t: unexpected response, expected none, actual %h", $time, got);
         error_count++;
      end else begin
         want = awaited_rsps.pop_front();
         report_field("top_value", want.top_value, got.top_value);
         report_field("not_empty", 32'(want.not_empty), 32'(got.not_empty));
         report_field("stack_depth", 32'(want.stack_depth), 32'(got.stack_depth));
         report_field("compare_flag", 32'(want.compare_flag), 32'(got.compare_flag));
         report_field("status", 32'(want.status), 32'(got.status));
      end
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 5))
               0:       return 32'sh7FFF_FFFF;
               1:       return 32'sh8000_0000;
               2:       return '0;
               3:       return 32'shFFFF_FFFF;
               4:       return 32'sh0001_0000;
               default: return 32'shFFFF_0000;
            endcase
         end
         1, 2, 3: return {16'($urandom_range(0, 40) - 20), 16'h0000};
         4, 5:    return {16'($urandom_range(0, 40) - 20), 16'($urandom())};
         default: return $urandom();
      endcase
   endfunction

   task automatic queue_word(logic [3:0] cmd, logic signed [31:0] value, bit drain);
      pending_type p;
      p.word.command    = cmd;
      p.word.push_value = value;
      p.drain           = drain;
      command_queue.push_back(p);
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         gap_left  = 0;
      end else if (!start || word_taken) begin
         if (start) begin
            if (burst_left > 0) begin
               burst_left--;
               gap_left = 0;
            end else begin
               gap_left = $urandom_range(0, 7);
               if ($urandom_range(0, 39) == 0) burst_left = $urandom_range(20, 60);
            end
         end
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (command_queue.size() == 0 ||
                      (command_queue[0].drain && awaited_rsps.size() != 0)) begin
            start <= 1'b0;
         end else begin
            next_item = command_queue.pop_front();
            req_word <= next_item.word;
            start    <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         word_taken <= 1'b0;
      end else begin
         if (rsp_strobe) check_rsp(rsp_word);
         if (start && !busy) awaited_rsps.push_back(apply_command(req_word));
         word_taken <= start && !busy;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int         produced;
      int         count;
      int         i;
      bit         drain;
      logic [3:0] op;

      // directed corners
      queue_word(sce_pkg::CMD_POP,   '0, 1'b0);            // pop on empty
      queue_word(sce_pkg::CMD_CLEAR, '0, 1'b0);
      queue_word(sce_pkg::CMD_PUSH,  32'sh7FFF_FFFF, 1'b0);
      queue_word(sce_pkg::CMD_EQ,    '0, 1'b0);            // binary op with one entry
      queue_word(sce_pkg::CMD_PUSH,  32'sh7FFF_FFFF, 1'b0);
      queue_word(sce_pkg::CMD_ADD,   '0, 1'b0);            // saturates high
      queue_word(sce_pkg::CMD_PUSH,  32'sh8000_0000, 1'b0);
      queue_word(sce_pkg::CMD_MUL,   '0, 1'b0);            // saturates low
      queue_word(sce_pkg::CMD_PUSH,  '0, 1'b0);
      queue_word(sce_pkg::CMD_DIV,   '0, 1'b0);            // zero divisor
      queue_word(sce_pkg::CMD_POP,   '0, 1'b0);
      queue_word(sce_pkg::CMD_PUSH,  32'shFFFF_FFFF, 1'b0);
      queue_word(sce_pkg::CMD_DIV,   '0, 1'b0);            // quotient overflow
      queue_word(sce_pkg::CMD_PUSH,  32'sh0000_8000, 1'b0);
      queue_word(sce_pkg::CMD_MOD,   '0, 1'b0);            // divisor integer part zero
      queue_word(sce_pkg::CMD_SUB,   '0, 1'b0);
      queue_word(sce_pkg::CMD_PUSH,  32'shFFFD_0000, 1'b0);
      queue_word(sce_pkg::CMD_MOD,   '0, 1'b0);            // negative divisor
      queue_word(sce_pkg::CMD_PUSH,  32'shFFFE_0000, 1'b0);
      queue_word(sce_pkg::CMD_NEQ,   '0, 1'b0);
      queue_word(sce_pkg::CMD_PUSH,  32'sh0001_0000, 1'b0);
      queue_word(sce_pkg::CMD_PUSH,  32'sh0001_0000, 1'b0);
      queue_word(sce_pkg::CMD_LE,    '0, 1'b0);
      queue_word(CMD_SPARE_LO, $urandom(), 1'b0);
      queue_word(CMD_SPARE_HI, $urandom(), 1'b0);

      produced = 0;
      drain    = 1'b1;
      while (produced < RANDOM_WORDS) begin
         case ($urandom_range(0, 19))
            0: begin
               count = STACK_SIZE + $urandom_range(1, 3);
               for (i = 0; i < count; i++) begin
                  queue_word(sce_pkg::CMD_PUSH, pick_value(), drain);
                  drain = 1'b0;
               end
               produced += count;
            end
            1: begin
               queue_word($urandom_range(0, 1) ? sce_pkg::CMD_CLEAR : sce_pkg::CMD_POP,
                          pick_value(), drain);
               produced++;
            end
            2, 3, 4: begin
               count = $urandom_range(1, 3);
               for (i = 0; i < count; i++) begin
                  queue_word(4'($urandom()), $urandom(), drain);
                  drain = 1'b0;
               end
               produced += count;
            end
            default: begin
               count = $urandom_range(1, 3);
               for (i = 0; i < count; i++) begin
                  queue_word(sce_pkg::CMD_PUSH, pick_value(), drain);
                  drain = 1'b0;
               end
               op = 4'($urandom_range(sce_pkg::CMD_ADD, sce_pkg::CMD_GE));
               queue_word(op, pick_value(), 1'b0);
               produced += count + 1;
               if ($urandom_range(0, 2) == 0) begin
                  op = 4'($urandom_range(sce_pkg::CMD_ADD, sce_pkg::CMD_GE));
                  queue_word(op, pick_value(), 1'b0);
                  produced++;
               end
            end
         endcase
         drain = ($urandom_range(0, 49) == 0);
      end

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      wait (command_queue.size() == 0 && !start && awaited_rsps.size() == 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
